// ----- src/assert_macros.svh -----
// Assertion macros for the RTL top level; clk and rst_n come from the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LTS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define LTS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- src/lts_pkg.sv -----
// Shared types, field widths and codes of the LRU tag store.
package lts_pkg;

  // Default number of entries.
  localparam int ENTRIES_DEF = 16;

  // Field widths.
  localparam int KIND_W  = 2;
  localparam int KEY_W   = 64;
  localparam int LEN_W   = 16;
  localparam int TTL_W   = 32;
  localparam int NOW_W   = 48;
  localparam int EXP_W   = 49;
  localparam int STAMP_W = 64;
  localparam int STAT_W  = 2;
  localparam int SLOT_W  = 4;

  // One tag RAM word: key, length, expiry time and recency stamp.
  localparam int WORD_W = KEY_W + LEN_W + EXP_W + STAMP_W;

  // Reset value of the largest accepted set length.
  localparam logic [LEN_W-1:0] MAX_BYTES_RST = LEN_W'(4096);

  // Request kinds.
  localparam logic [KIND_W-1:0] KIND_GET   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SET   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EVICT = 2'd2;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_MISS   = 2'd1;
  localparam logic [STAT_W-1:0] ST_LARGE  = 2'd2;
  localparam logic [STAT_W-1:0] ST_BADLEN = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture a new request and clear the scan results
    logic rd_en;   // read the tag RAM at the scan address
    logic eval;    // RAM read data is valid for the evaluated index
    logic finish;  // resolve the request, update state, emit the result
  } lts_cmd_t;

endpackage

// ----- src/lts_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module lts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/lts_ctrl.sv -----
// Controller: sequences the per-request scan over all entries and the final update.
module lts_ctrl import lts_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF,
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  output lts_cmd_t         cmd,
  output logic [IDX_W-1:0] rd_addr,
  output logic [IDX_W-1:0] eval_idx
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DRAIN  = 2'd2;
  localparam logic [1:0] S_DECIDE = 2'd3;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  logic [1:0]       state_r, state_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic             eval_r;
  logic [IDX_W-1:0] eval_idx_r;

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_SCAN;
          cnt_nxt   = '0;
        end
      end
      S_SCAN: begin
        if (cnt_r == LAST_IDX) begin
          state_nxt = S_DRAIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DRAIN: begin
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State, scan counter and read-data tracking.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      eval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      eval_r  <= (state_r == S_SCAN);
    end
  end

  // The index whose read data arrives in the next cycle.
  always_ff @(posedge clk) begin
    eval_idx_r <= cnt_r;
  end

  // Commands and status.
  always_comb begin
    cmd.load   = (state_r == S_IDLE) && start;
    cmd.rd_en  = (state_r == S_SCAN);
    cmd.eval   = eval_r;
    cmd.finish = (state_r == S_DECIDE);
  end

  assign busy     = (state_r != S_IDLE);
  assign rd_addr  = cnt_r;
  assign eval_idx = eval_idx_r;

endmodule

// ----- src/lts_dpath.sv -----
// Datapath: request registers, tag RAM, scan results, valid bits and result registers.
module lts_dpath import lts_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF,
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  lts_cmd_t           cmd,
  input  logic [IDX_W-1:0]   rd_addr,
  input  logic [IDX_W-1:0]   eval_idx,
  input  logic [KIND_W-1:0]  in_kind,
  input  logic [KEY_W-1:0]   in_key,
  input  logic [LEN_W-1:0]   in_value_len,
  input  logic [LEN_W-1:0]   in_read_capacity,
  input  logic [TTL_W-1:0]   in_ttl_ms,
  input  logic [NOW_W-1:0]   in_now_ms,
  input  logic               cfg_wr,
  input  logic [LEN_W-1:0]   cfg_data,
  output logic               out_valid,
  output logic [STAT_W-1:0]  out_status,
  output logic [SLOT_W-1:0]  out_slot,
  output logic [LEN_W-1:0]   out_stored_len
);

  // Request registers.
  logic [KIND_W-1:0]  kind_r;
  logic [KEY_W-1:0]   key_r;
  logic [LEN_W-1:0]   vlen_r;
  logic [LEN_W-1:0]   rcap_r;
  logic [NOW_W-1:0]   now_r;
  logic [EXP_W-1:0]   exp_new_r;

  // Configuration and shared state.
  logic [LEN_W-1:0]   max_bytes_r;
  logic [STAMP_W-1:0] use_r, use_nxt;
  logic [ENTRIES-1:0] valid_r;

  // Scan results.
  logic               match_found_r;
  logic [IDX_W-1:0]   match_idx_r;
  logic [LEN_W-1:0]   match_len_r;
  logic [EXP_W-1:0]   match_exp_r;
  logic               free_found_r;
  logic [IDX_W-1:0]   free_idx_r;
  logic               best_found_r;
  logic [IDX_W-1:0]   best_idx_r;
  logic [STAMP_W-1:0] best_stamp_r;

  // RAM ports and unpacked read word.
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [WORD_W-1:0]  ram_wdata;
  logic [WORD_W-1:0]  ram_rdata;
  logic [KEY_W-1:0]   rd_key;
  logic [LEN_W-1:0]   rd_len;
  logic [EXP_W-1:0]   rd_exp;
  logic [STAMP_W-1:0] rd_stamp;
  logic               rd_valid;

  // Resolution of the request.
  logic               set_v;
  logic               clr_v;
  logic [IDX_W-1:0]   v_idx;
  logic [STAT_W-1:0]  status_nxt;
  logic [IDX_W-1:0]   slot_nxt;
  logic [LEN_W-1:0]   slen_nxt;
  logic [IDX_W-1:0]   set_idx;

  // Result registers.
  logic               out_valid_r;
  logic [STAT_W-1:0]  out_status_r;
  logic [SLOT_W-1:0]  out_slot_r;
  logic [LEN_W-1:0]   out_stored_len_r;

  // Tag RAM: one entry read per scan cycle, one write at resolution.
  lts_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ENTRIES)
  ) u_tag_ram (
    .clk   (clk),
    .we    (ram_we && cmd.finish),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd_en),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  assign {rd_key, rd_len, rd_exp, rd_stamp} = ram_rdata;
  assign rd_valid = valid_r[eval_idx];

  // Capture the request; the new expiry time is formed here once.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r    <= in_kind;
      key_r     <= in_key;
      vlen_r    <= in_value_len;
      rcap_r    <= in_read_capacity;
      now_r     <= in_now_ms;
      exp_new_r <= {1'b0, in_now_ms} + EXP_W'(in_ttl_ms);
    end
  end

  // Scan: first valid key match, first free entry, and the lowest stamp
  // among valid entries with ties going to the lower index.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      match_found_r <= 1'b0;
      free_found_r  <= 1'b0;
      best_found_r  <= 1'b0;
    end else if (cmd.eval) begin
      if (rd_valid && (rd_key == key_r) && !match_found_r) begin
        match_found_r <= 1'b1;
        match_idx_r   <= eval_idx;
        match_len_r   <= rd_len;
        match_exp_r   <= rd_exp;
      end
      if (!rd_valid && !free_found_r) begin
        free_found_r <= 1'b1;
        free_idx_r   <= eval_idx;
      end
      if (rd_valid && (!best_found_r || (rd_stamp < best_stamp_r))) begin
        best_found_r <= 1'b1;
        best_idx_r   <= eval_idx;
        best_stamp_r <= rd_stamp;
      end
    end
  end

  // Target of a set: the matching entry, else the first free, else the LRU entry.
  always_comb begin
    if (match_found_r) begin
      set_idx = match_idx_r;
    end else if (free_found_r) begin
      set_idx = free_idx_r;
    end else begin
      set_idx = best_idx_r;
    end
  end

  // Resolve the request once the scan is complete.
  always_comb begin
    ram_we     = 1'b0;
    ram_waddr  = set_idx;
    ram_wdata  = {key_r, vlen_r, exp_new_r, use_r + 1'b1};
    set_v      = 1'b0;
    clr_v      = 1'b0;
    v_idx      = set_idx;
    status_nxt = ST_MISS;
    slot_nxt   = '0;
    slen_nxt   = '0;
    use_nxt    = use_r;
    case (kind_r)
      KIND_GET: begin
        if (match_found_r) begin
          if (match_exp_r < {1'b0, now_r}) begin
            // Expired entry is dropped and reported as a miss.
            clr_v = 1'b1;
            v_idx = match_idx_r;
          end else if (match_len_r > rcap_r) begin
            status_nxt = ST_LARGE;
          end else begin
            // Hit: refresh the stamp, rewriting the rest of the entry unchanged.
            ram_we     = 1'b1;
            ram_waddr  = match_idx_r;
            ram_wdata  = {key_r, match_len_r, match_exp_r, use_r + 1'b1};
            use_nxt    = use_r + 1'b1;
            status_nxt = ST_OK;
            slot_nxt   = match_idx_r;
            slen_nxt   = match_len_r;
          end
        end
      end
      KIND_SET: begin
        if (vlen_r == '0) begin
          status_nxt = ST_BADLEN;
        end else if (vlen_r > max_bytes_r) begin
          status_nxt = ST_LARGE;
        end else begin
          ram_we     = 1'b1;
          set_v      = 1'b1;
          use_nxt    = use_r + 1'b1;
          status_nxt = ST_OK;
          slot_nxt   = set_idx;
        end
      end
      KIND_EVICT: begin
        // Only a full store loses its least recently used entry.
        if (!free_found_r && best_found_r) begin
          clr_v      = 1'b1;
          v_idx      = best_idx_r;
          status_nxt = ST_OK;
          slot_nxt   = best_idx_r;
        end
      end
      default: begin
        status_nxt = ST_MISS;
      end
    endcase
  end

  // Configuration register, valid bits and use counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_bytes_r <= MAX_BYTES_RST;
      valid_r     <= '0;
      use_r       <= '0;
    end else begin
      if (cfg_wr) begin
        max_bytes_r <= cfg_data;
      end
      if (cmd.finish) begin
        use_r <= use_nxt;
        if (set_v) begin
          valid_r[v_idx] <= 1'b1;
        end else if (clr_v) begin
          valid_r[v_idx] <= 1'b0;
        end
      end
    end
  end

  // Result strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_status_r     <= status_nxt;
      out_slot_r       <= SLOT_W'(slot_nxt);
      out_stored_len_r <= slen_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_slot       = out_slot_r;
  assign out_stored_len = out_stored_len_r;

endmodule

// ----- src/lru_ttl_tag_store_core.sv -----
// Top level of the LRU tag store with per-entry expiry time.
//
// A request is taken when start is high and busy is low, and then busy stays
// high while the tag RAM is walked one entry at a time through its single
// read port, while the last read data arrives and while the request is
// resolved and written back. The result appears on out_status, out_slot and
// out_stored_len for exactly one cycle with out_valid high, in the first
// cycle with busy low again; the receiver cannot stall it and must take it
// then. A new request may be started in that same cycle. Entry state needs
// no clearing after reset, so requests are accepted right away. The max_bytes
// register is written through cfg_valid/cfg_data, which is always ready;
// write it only while no request is in progress.
`include "assert_macros.svh"

module lru_ttl_tag_store_core import lts_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [KIND_W-1:0]  in_kind,
  input  logic [KEY_W-1:0]   in_key,
  input  logic [LEN_W-1:0]   in_value_len,
  input  logic [LEN_W-1:0]   in_read_capacity,
  input  logic [TTL_W-1:0]   in_ttl_ms,
  input  logic [NOW_W-1:0]   in_now_ms,
  output logic               out_valid,
  output logic [STAT_W-1:0]  out_status,
  output logic [SLOT_W-1:0]  out_slot,
  output logic [LEN_W-1:0]   out_stored_len,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [LEN_W-1:0]   cfg_data
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  lts_cmd_t         cmd;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] eval_idx;

  // The configuration register can be written in any cycle.
  assign cfg_ready = 1'b1;

  // Controller.
  lts_ctrl #(
    .ENTRIES (ENTRIES)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .cmd      (cmd),
    .rd_addr  (rd_addr),
    .eval_idx (eval_idx)
  );

  // Datapath.
  lts_dpath #(
    .ENTRIES (ENTRIES)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .rd_addr          (rd_addr),
    .eval_idx         (eval_idx),
    .in_kind          (in_kind),
    .in_key           (in_key),
    .in_value_len     (in_value_len),
    .in_read_capacity (in_read_capacity),
    .in_ttl_ms        (in_ttl_ms),
    .in_now_ms        (in_now_ms),
    .cfg_wr           (cfg_valid && cfg_ready),
    .cfg_data         (cfg_data),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_slot         (out_slot),
    .out_stored_len   (out_stored_len)
  );

  // An accepted request keeps the block busy in the next cycle.
  `LTS_ASSERT_NEXT(a_start_busy, start && !busy, busy)
  // Every resolution produces exactly the result strobe that follows it.
  `LTS_ASSERT_NEXT(a_finish_result, cmd.finish, out_valid)
  // A result is only shown once the block has gone idle.
  `LTS_ASSERT_IMPL(a_result_idle, out_valid, !busy)
  // Anything but success carries a zero slot and a zero length.
  `LTS_ASSERT_IMPL(a_fail_zero, out_valid && (out_status != ST_OK),
                   (out_slot == '0) && (out_stored_len == '0))

endmodule

// ----- bench/lru_ttl_tag_store_checker.sv -----
`timescale 1ns / 100ps
// Checker that predicts the tag store results and compares them with the core outputs.
module lru_ttl_tag_store_checker import lts_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  logic [KIND_W-1:0] in_kind,
  input  logic [KEY_W-1:0]  in_key,
  input  logic [LEN_W-1:0]  in_value_len,
  input  logic [LEN_W-1:0]  in_read_capacity,
  input  logic [TTL_W-1:0]  in_ttl_ms,
  input  logic [NOW_W-1:0]  in_now_ms,
  input  logic              out_valid,
  input  logic [STAT_W-1:0] out_status,
  input  logic [SLOT_W-1:0] out_slot,
  input  logic [LEN_W-1:0]  out_stored_len,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [LEN_W-1:0]  cfg_data,
  output int                fail_count,
  output int                pending
);

  // One answer of the tag store.
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] slot;
    logic [LEN_W-1:0]  stored_len;
  } lookup_result_t;

  // Shadow copy of the tag store and its limit register.
  logic                tag_valid  [ENTRIES];
  logic [KEY_W-1:0]    tag_key    [ENTRIES];
  logic [LEN_W-1:0]    tag_len    [ENTRIES];
  logic [EXP_W-1:0]    tag_expiry [ENTRIES];
  logic [STAMP_W-1:0]  tag_stamp  [ENTRIES];
  logic [STAMP_W-1:0]  use_count;
  logic [LEN_W-1:0]    max_bytes;

  // Answers predicted for accepted requests, oldest first.
  lookup_result_t answer_q[$];

  // A dropped entry goes back to all zeros.
  function automatic void drop_entry(int s);
    tag_valid[s]  = 1'b0;
    tag_key[s]    = '0;
    tag_len[s]    = '0;
    tag_expiry[s] = '0;
    tag_stamp[s]  = '0;
  endfunction

  // The lowest valid entry holding the key, or -1.
  function automatic int find_key(logic [KEY_W-1:0] key);
    for (int s = 0; s < ENTRIES; s++) begin
      if (tag_valid[s] && tag_key[s] == key) begin
        return s;
      end
    end
    return -1;
  endfunction

  // The first free entry, else the oldest stamp with ties to the lower index.
  function automatic int pick_victim();
    int best;
    best = -1;
    for (int s = 0; s < ENTRIES; s++) begin
      if (!tag_valid[s]) begin
        return s;
      end
      if (best < 0 || tag_stamp[s] < tag_stamp[best]) begin
        best = s;
      end
    end
    return best;
  endfunction

  // Applies one request to the shadow store and returns its answer.
  function automatic lookup_result_t apply_request(
    logic [KIND_W-1:0] kind,
    logic [KEY_W-1:0]  key,
    logic [LEN_W-1:0]  vlen,
    logic [LEN_W-1:0]  rcap,
    logic [TTL_W-1:0]  ttl,
    logic [NOW_W-1:0]  now
  );
    lookup_result_t res;
    int s;
    res = '{status: ST_MISS, slot: '0, stored_len: '0};
    case (kind)
      KIND_GET: begin
        s = find_key(key);
        if (s >= 0) begin
          if (tag_expiry[s] < EXP_W'(now)) begin
            drop_entry(s);
          end else if (tag_len[s] > rcap) begin
            res.status = ST_LARGE;
          end else begin
            use_count = use_count + 1'b1;
            tag_stamp[s] = use_count;
            res = '{status: ST_OK, slot: SLOT_W'(s), stored_len: tag_len[s]};
          end
        end
      end
      KIND_SET: begin
        if (vlen == '0) begin
          res.status = ST_BADLEN;
        end else if (vlen > max_bytes) begin
          res.status = ST_LARGE;
        end else begin
          s = find_key(key);
          if (s < 0) begin
            s = pick_victim();
          end
          if (s >= 0) begin
            tag_valid[s]  = 1'b1;
            tag_key[s]    = key;
            tag_len[s]    = vlen;
            tag_expiry[s] = EXP_W'(now) + EXP_W'(ttl);
            use_count     = use_count + 1'b1;
            tag_stamp[s]  = use_count;
            res.status    = ST_OK;
            res.slot      = SLOT_W'(s);
          end
        end
      end
      KIND_EVICT: begin
        s = pick_victim();
        if (s >= 0 && tag_valid[s]) begin
          drop_entry(s);
          res.status = ST_OK;
          res.slot   = SLOT_W'(s);
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  // Counts a failure; only the first ten are printed in full.
  task automatic report_failure(string what, lookup_result_t want, lookup_result_t got);
    if (fail_count < 10) begin
      $display("%0t %s: expected status %0d slot %0d len %0d, got status %0d slot %0d len %0d",
               $time, what, want.status, want.slot, want.stored_len,
               got.status, got.slot, got.stored_len);
    end
    fail_count++;
  endtask

  // Register writes first, then the result transfer, then the request transfer.
  always @(posedge clk) begin
    lookup_result_t want;
    lookup_result_t got;
    if (!rst_n) begin
      for (int s = 0; s < ENTRIES; s++) begin
        drop_entry(s);
      end
      use_count  = '0;
      max_bytes  = MAX_BYTES_RST;
      answer_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        max_bytes = cfg_data;
      end
      if (out_valid) begin
        got = '{status: out_status, slot: out_slot, stored_len: out_stored_len};
        if (answer_q.size() == 0) begin
          report_failure("unexpected result", '0, got);
        end else begin
          want = answer_q.pop_front();
          if (want.status != got.status || want.slot != got.slot ||
              want.stored_len != got.stored_len) begin
            report_failure("mismatch", want, got);
          end
        end
      end
      if (start && !busy) begin
        answer_q.push_back(apply_request(in_kind, in_key, in_value_len, in_read_capacity,
                                         in_ttl_ms, in_now_ms));
      end
    end
    pending = answer_q.size();
  end

endmodule

// ----- bench/lru_ttl_tag_store_core_tb.sv -----
`timescale 1ns / 100ps
// Testbench top that drives requests and limit writes into the tag store and gives the verdict.
module lru_ttl_tag_store_core_tb;
  import lts_pkg::*;

  // Request code that the core does not define.
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT  = 250000;
  localparam int KEY_POOL     = 24;
  localparam int DRAIN_CYCLES = 24;

  logic              clk;
  logic              rst_n            = 1'b0;
  logic              start            = 1'b0;
  logic [KIND_W-1:0] in_kind          = KIND_GET;
  logic [KEY_W-1:0]  in_key           = '0;
  logic [LEN_W-1:0]  in_value_len     = '0;
  logic [LEN_W-1:0]  in_read_capacity = '0;
  logic [TTL_W-1:0]  in_ttl_ms        = '0;
  logic [NOW_W-1:0]  in_now_ms        = '0;
  logic              cfg_valid        = 1'b0;
  logic [LEN_W-1:0]  cfg_data         = '0;
  logic              busy;
  logic              out_valid;
  logic [STAT_W-1:0] out_status;
  logic [SLOT_W-1:0] out_slot;
  logic [LEN_W-1:0]  out_stored_len;
  logic              cfg_ready;
  int                fail_count;
  int                pending;
  int                cycle_count = 0;

  // Keys reused by the random requests so that hits and evictions happen.
  logic [KEY_W-1:0]  key_pool [KEY_POOL];
  logic [NOW_W-1:0]  clock_ms;
  logic [LEN_W-1:0]  max_bytes = MAX_BYTES_RST;

  // Percentage of cycles in which the sender holds start low.
  int                idle_share = 0;

  // Free-running 20 ns clock.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  lru_ttl_tag_store_core i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_kind          (in_kind),
    .in_key           (in_key),
    .in_value_len     (in_value_len),
    .in_read_capacity (in_read_capacity),
    .in_ttl_ms        (in_ttl_ms),
    .in_now_ms        (in_now_ms),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_slot         (out_slot),
    .out_stored_len   (out_stored_len),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  lru_ttl_tag_store_checker i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_kind          (in_kind),
    .in_key           (in_key),
    .in_value_len     (in_value_len),
    .in_read_capacity (in_read_capacity),
    .in_ttl_ms        (in_ttl_ms),
    .in_now_ms        (in_now_ms),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_slot         (out_slot),
    .out_stored_len   (out_stored_len),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Presents one request and returns at the edge of its transfer; start stays high.
  // Until then start is dropped at random in the share of cycles given by idle_share.
  task automatic issue(input logic [KIND_W-1:0] kind, input logic [KEY_W-1:0] key,
                       input logic [LEN_W-1:0] vlen, input logic [LEN_W-1:0] rcap,
                       input logic [TTL_W-1:0] ttl, input logic [NOW_W-1:0] now);
    logic taken;
    in_kind          <= kind;
    in_key           <= key;
    in_value_len     <= vlen;
    in_read_capacity <= rcap;
    in_ttl_ms        <= ttl;
    in_now_ms        <= now;
    start            <= ($urandom_range(99) >= idle_share);
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = start && !busy;
      if (!taken) begin
        start <= ($urandom_range(99) >= idle_share);
      end
    end
  endtask

  // Waits until every predicted answer has been seen, then realigns to the clock edge.
  task automatic wait_idle();
    start <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  // Writes the length limit while the core is idle.
  task automatic write_max(input logic [LEN_W-1:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    max_bytes = value;
  endtask

  // Edges of every field and corners of lookup, expiry and set; eviction only on a store that is not full.
  task automatic run_directed();
    logic [KEY_W-1:0] k0;
    k0 = key_pool[0];
    issue(KIND_GET,    k0, '0, '1, '0, 48'd1000);
    issue(KIND_EVICT,  '0, '0, '0, '0, 48'd1000);
    issue(KIND_SET,    k0, '0, '0, 32'd100, 48'd1000);
    issue(KIND_SET,    k0, MAX_BYTES_RST + 1'b1, '0, 32'd100, 48'd1000);
    issue(KIND_SET,    k0, MAX_BYTES_RST, '0, 32'd100, 48'd1000);
    issue(KIND_GET,    k0, '0, MAX_BYTES_RST - 1'b1, '0, 48'd1000);
    issue(KIND_GET,    k0, '0, MAX_BYTES_RST, '0, 48'd1000);
    issue(KIND_SET,    '1, 16'd1, '1, '1, '1);
    issue(KIND_GET,    '1, '1, '1, '1, '1);
    // Expiry equal to the current time still hits; one later it drops the entry.
    issue(KIND_GET,    k0, '0, '1, '0, 48'd1100);
    issue(KIND_GET,    k0, '0, '1, '0, 48'd1101);
    issue(KIND_GET,    k0, '0, '1, '0, 48'd1000);
    issue(KIND_UNUSED, k0, 16'd5, '1, 32'd5, 48'd1000);
    issue(KIND_SET,    '0, 16'd9, '0, '0, 48'd1000);
    issue(KIND_SET,    key_pool[1], 16'd12, '0, 32'd50, 48'd1000);
    issue(KIND_SET,    '0, 16'd20, '0, '0, 48'd1000);
    // A free entry remains, so nothing is evicted.
    issue(KIND_EVICT,  k0, '0, '0, '0, 48'd1000);
    issue(KIND_GET,    '0, '0, 16'd20, '0, 48'd1000);
  endtask

  // Builds one random request, mostly on pooled keys with a slowly advancing clock.
  task automatic random_item();
    int               pick;
    logic [KIND_W-1:0] kind;
    logic [KEY_W-1:0]  key;
    logic [LEN_W-1:0]  vlen;
    logic [LEN_W-1:0]  rcap;
    logic [TTL_W-1:0]  ttl;
    logic [NOW_W-1:0]  now;
    pick = $urandom_range(99);
    if (pick < 42) begin
      kind = KIND_GET;
    end else if (pick < 82) begin
      kind = KIND_SET;
    end else if (pick < 96) begin
      kind = KIND_EVICT;
    end else begin
      kind = KIND_UNUSED;
    end
    if ($urandom_range(9) == 0) begin
      key = {$urandom, $urandom};
    end else begin
      key = key_pool[$urandom_range(KEY_POOL - 1)];
    end
    // Lengths cluster around the current limit and small values.
    pick = $urandom_range(99);
    if (pick < 5) begin
      vlen = '0;
    end else if (pick < 15) begin
      vlen = max_bytes;
    end else if (pick < 22) begin
      vlen = max_bytes + 1'b1;
    end else if (pick < 32) begin
      vlen = LEN_W'($urandom);
    end else begin
      vlen = LEN_W'($urandom_range(1, 300));
    end
    pick = $urandom_range(99);
    if (pick < 35) begin
      rcap = '1;
    end else if (pick < 75) begin
      rcap = LEN_W'($urandom_range(0, 320));
    end else begin
      rcap = LEN_W'($urandom);
    end
    pick = $urandom_range(99);
    if (pick < 10) begin
      ttl = '0;
    end else if (pick < 20) begin
      ttl = $urandom;
    end else begin
      ttl = TTL_W'($urandom_range(1, 400));
    end
    clock_ms = clock_ms + NOW_W'($urandom_range(0, 12));
    if ($urandom_range(49) == 0) begin
      now = NOW_W'({$urandom, $urandom});
    end else begin
      now = clock_ms;
    end
    issue(kind, key, vlen, rcap, ttl, now);
  endtask

  // Random requests with start held low in the given share of cycles.
  task automatic run_phase(input int items, input int idle_pct);
    idle_share = idle_pct;
    repeat (items) begin
      random_item();
    end
    idle_share = 0;
  endtask

  // Reset, directed requests, then random phases under several length limits.
  initial begin
    for (int idx = 0; idx < KEY_POOL; idx++) begin
      key_pool[idx] = {$urandom, $urandom};
    end
    clock_ms = 48'd1200;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    write_max(16'hFFFF);
    run_phase(280, 16);
    write_max(16'd0);
    run_phase(20, 16);
    write_max(LEN_W'($urandom_range(64, 200)));
    run_phase(300, 51);
    write_max(16'd1);
    run_phase(20, 51);
    write_max(MAX_BYTES_RST);
    run_phase(280, 0);
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
